>>> src/wdb_pkg.sv
`default_nettype none

package wdb_pkg;

    // Field widths fixed by the item formats.
    localparam int unsigned ACT_W    = 2;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned HANDLE_W = 64;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ECNT_W   = 5;

    // Results per check item and the width of the result counter.
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Backoff growth cap in milliseconds.
    localparam logic [MS_W-1:0] GROW_CAP_MS = MS_W'(5000);

    // Configuration port.
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam int unsigned REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_THR = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_BT_MIN  = 1'b1;
    localparam logic [MS_W-1:0] MIN_THR_RESET = MS_W'(1000);
    localparam logic [MS_W-1:0] BT_MIN_RESET  = MS_W'(300000);

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_REGISTER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_KICK     = 2'd2;
    localparam logic [ACT_W-1:0] ACT_CHECK    = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RAISED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RECOVERED = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERDUE   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd7;

    // One stored channel.
    typedef struct packed {
        logic [ID_W-1:0]     channel;
        logic [HANDLE_W-1:0] handle;
        logic [MS_W-1:0]     threshold;
        logic [MS_W-1:0]     last_kick;
        logic [MS_W-1:0]     limit;
    } entry_t;

    // One result without its per-item tags.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     channel;
        logic [HANDLE_W-1:0] handle;
        logic                backtrace;
        logic [MS_W-1:0]     limit;
    } res_t;

    // Configuration register values.
    typedef struct packed {
        logic [MS_W-1:0] min_thr;
        logic [MS_W-1:0] bt_min;
    } cfg_t;

    // Output of the shared compare and add unit.
    typedef struct packed {
        logic            hit;
        logic            late;
        logic            backtrace;
        logic [MS_W-1:0] grown;
    } unit_res_t;

    function automatic res_t make_res(
        input logic [STATUS_W-1:0] status,
        input logic [ID_W-1:0]     channel,
        input logic [HANDLE_W-1:0] handle,
        input logic                backtrace,
        input logic [MS_W-1:0]     limit
    );
        res_t r;
        r.status    = status;
        r.channel   = channel;
        r.handle    = handle;
        r.backtrace = backtrace;
        r.limit     = limit;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/wdb_if.sv
`default_nettype none

// Request channel: one item per action.
interface wdb_req_if;
    logic                               valid;
    logic                               ready;
    logic [wdb_pkg::ACT_W-1:0]          action;
    logic [wdb_pkg::ID_W-1:0]           channel_id;
    logic [wdb_pkg::HANDLE_W-1:0]       target_handle;
    logic [wdb_pkg::MS_W-1:0]           threshold_ms;
    logic [wdb_pkg::MS_W-1:0]           now_ms;

    modport source (
        output valid, action, channel_id, target_handle, threshold_ms, now_ms,
        input  ready
    );
    modport sink (
        input  valid, action, channel_id, target_handle, threshold_ms, now_ms,
        output ready
    );
endinterface

// Response channel: one or more items per request.
interface wdb_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [wdb_pkg::STATUS_W-1:0]       status;
    logic [wdb_pkg::ID_W-1:0]           result_channel;
    logic [wdb_pkg::HANDLE_W-1:0]       result_handle;
    logic                               backtrace_request;
    logic [wdb_pkg::MS_W-1:0]           limit_ms;
    logic [wdb_pkg::ECNT_W-1:0]         entry_count;
    logic                               last_result;

    modport source (
        output valid, status, result_channel, result_handle, backtrace_request,
               limit_ms, entry_count, last_result,
        input  ready
    );
    modport sink (
        input  valid, status, result_channel, result_handle, backtrace_request,
               limit_ms, entry_count, last_result,
        output ready
    );
endinterface

`default_nettype wire

>>> src/wdb_cfg.sv
`default_nettype none

module wdb_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wdb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [wdb_pkg::PDATA_W-1:0]   pwdata,
    output logic      [wdb_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output wdb_pkg::cfg_t                      cfg
);

    logic [wdb_pkg::MS_W-1:0]      min_thr_reg;
    logic [wdb_pkg::MS_W-1:0]      bt_min_reg;
    logic [wdb_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_en;

    // Registers sit on a word grid; low address bits are ignored.
    assign reg_idx = paddr[wdb_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_thr_reg <= wdb_pkg::MIN_THR_RESET;
            bt_min_reg  <= wdb_pkg::BT_MIN_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == wdb_pkg::REG_MIN_THR)
            begin
                min_thr_reg <= pwdata;
            end
            else
            begin
                bt_min_reg <= pwdata;
            end
        end
    end

    // Read mux.
    assign prdata = (reg_idx == wdb_pkg::REG_MIN_THR) ? min_thr_reg : bt_min_reg;

    assign cfg.min_thr = min_thr_reg;
    assign cfg.bt_min  = bt_min_reg;

endmodule

`default_nettype wire

>>> src/wdb_mem.sv
`default_nettype none

module wdb_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire wdb_pkg::entry_t wdata,
    input  wire logic            re,
    input  wire logic [AW-1:0]   raddr,
    output wdb_pkg::entry_t      rdata
);

    wdb_pkg::entry_t mem [DEPTH];

    // One write port, one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/wdb_unit.sv
`default_nettype none

module wdb_unit (
    input  wire wdb_pkg::entry_t             ent,
    input  wire logic [wdb_pkg::ID_W-1:0]    chan,
    input  wire logic [wdb_pkg::MS_W-1:0]    now,
    input  wire logic [wdb_pkg::MS_W-1:0]    bt_min,
    input  wire logic                        use_thr,
    output wdb_pkg::unit_res_t               res
);

    logic [wdb_pkg::MS_W-1:0] base;
    logic [wdb_pkg::MS_W:0]   deadline;
    logic [wdb_pkg::MS_W-1:0] half;
    logic [wdb_pkg::MS_W-1:0] grow;
    logic [wdb_pkg::MS_W:0]   sum;

    // Deadline test against threshold (kick) or current limit (check).
    assign base     = use_thr ? ent.threshold : ent.limit;
    assign deadline = {1'b0, ent.last_kick} + {1'b0, base};

    // Backoff: limit grows by half of itself, capped, saturating at the top.
    assign half = ent.limit >> 1;
    assign grow = (half < wdb_pkg::GROW_CAP_MS) ? half : wdb_pkg::GROW_CAP_MS;
    assign sum  = {1'b0, ent.limit} + {1'b0, grow};

    assign res.hit       = (ent.channel == chan);
    assign res.late      = ({1'b0, now} > deadline);
    assign res.backtrace = (ent.limit > bt_min);
    assign res.grown     = sum[wdb_pkg::MS_W] ? {wdb_pkg::MS_W{1'b1}}
                                              : sum[wdb_pkg::MS_W-1:0];

endmodule

`default_nettype wire

>>> src/wdb_seq.sv
`default_nettype none

module wdb_seq #(
    parameter int unsigned TABLE_ENTRIES = 16,
    parameter int unsigned AW            = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    wdb_req_if.sink              req,
    wdb_rsp_if.source            rsp,
    input  wire wdb_pkg::cfg_t   cfg,
    input  wire wdb_pkg::unit_res_t urs,
    output logic                 use_thr,
    output logic                 mem_we,
    output logic [AW-1:0]        mem_waddr,
    output wdb_pkg::entry_t      mem_wdata,
    output logic                 mem_re,
    output logic [AW-1:0]        mem_raddr,
    input  wire wdb_pkg::entry_t mem_rdata,
    output logic [wdb_pkg::ID_W-1:0] item_chan,
    output logic [wdb_pkg::MS_W-1:0] item_now
);

    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EV    = 3'd2;
    localparam logic [2:0] S_SH_RD = 3'd3;
    localparam logic [2:0] S_SH_WR = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                       state_reg, state_next;
    logic [CW-1:0]                    idx_reg, idx_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [wdb_pkg::RES_CNT_W-1:0]    n_reg, n_next;
    logic                             pend_valid_reg, pend_valid_next;
    wdb_pkg::res_t                    pend_reg, pend_next;
    logic                             out_valid_reg, out_valid_next;
    wdb_pkg::res_t                    out_res_reg, out_res_next;
    logic                             out_last_reg, out_last_next;
    logic [wdb_pkg::ECNT_W-1:0]       out_cnt_reg, out_cnt_next;

    logic [wdb_pkg::ACT_W-1:0]        act_reg;
    logic [wdb_pkg::ID_W-1:0]         chan_reg;
    logic [wdb_pkg::HANDLE_W-1:0]     handle_reg;
    logic [wdb_pkg::MS_W-1:0]         thr_reg;
    logic [wdb_pkg::MS_W-1:0]         now_reg;

    logic                             accept;
    logic                             out_free;
    logic [CW:0]                      idx_p1;
    logic [CW:0]                      idx_p2;
    logic [CW:0]                      count_ext;
    logic                             scan_last;
    logic                             table_full;
    logic                             raised;
    logic [wdb_pkg::MS_W-1:0]         eff_thr;
    logic                             report;
    wdb_pkg::entry_t                  kick_ent;
    wdb_pkg::entry_t                  grow_ent;
    wdb_pkg::entry_t                  new_ent;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;

    assign idx_p1     = {1'b0, idx_reg} + (CW + 1)'(1);
    assign idx_p2     = {1'b0, idx_reg} + (CW + 1)'(2);
    assign count_ext  = {1'b0, count_reg};
    assign scan_last  = (idx_p1 == count_ext);
    assign table_full = (count_reg >= CW'(TABLE_ENTRIES));
    assign raised     = (thr_reg < cfg.min_thr);
    assign eff_thr    = raised ? cfg.min_thr : thr_reg;
    assign report     = urs.late && (n_reg < wdb_pkg::RES_CNT_W'(wdb_pkg::MAX_RESULTS));

    assign use_thr   = (act_reg == wdb_pkg::ACT_KICK);
    assign item_chan = chan_reg;
    assign item_now  = now_reg;

    // Modified copies of the entry under evaluation and a fresh entry.
    always_comb
    begin
        kick_ent           = mem_rdata;
        kick_ent.last_kick = now_reg;
        kick_ent.limit     = mem_rdata.threshold;
        grow_ent           = mem_rdata;
        grow_ent.limit     = urs.grown;
        new_ent.channel    = chan_reg;
        new_ent.handle     = handle_reg;
        new_ent.threshold  = eff_thr;
        new_ent.last_kick  = now_reg;
        new_ent.limit      = eff_thr;
    end

    // Sequencer: each visited table entry is read (S_RD) and then evaluated (S_EV).
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_res_next    = out_res_reg;
        out_last_next   = out_last_reg;
        out_cnt_next    = out_cnt_reg;
        mem_re          = 1'b0;
        mem_raddr       = idx_reg[AW-1:0];
        mem_we          = 1'b0;
        mem_waddr       = idx_reg[AW-1:0];
        mem_wdata       = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    state_next      = (count_reg == '0) ? S_END : S_RD;
                end
            end

            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_EV;
            end

            S_EV:
            begin
                if (act_reg == wdb_pkg::ACT_CHECK)
                begin
                    // Hold while a held result cannot yet move to the output.
                    if (!(report && pend_valid_reg && !out_free))
                    begin
                        if (urs.late)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = grow_ent;
                        end
                        if (report)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_res_next   = pend_reg;
                                out_last_next  = 1'b0;
                                out_cnt_next   = wdb_pkg::ECNT_W'(count_reg);
                            end
                            pend_next = wdb_pkg::make_res(wdb_pkg::ST_OVERDUE,
                                mem_rdata.channel, mem_rdata.handle, urs.backtrace,
                                mem_rdata.limit);
                            pend_valid_next = 1'b1;
                            n_next          = n_reg + wdb_pkg::RES_CNT_W'(1);
                        end
                        if (scan_last)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            idx_next   = idx_p1[CW-1:0];
                            state_next = S_RD;
                        end
                    end
                end
                else if (urs.hit)
                begin
                    pend_valid_next = 1'b1;
                    state_next      = S_FIN;
                    case (act_reg)
                        wdb_pkg::ACT_REGISTER:
                        begin
                            pend_next = wdb_pkg::make_res(wdb_pkg::ST_DUPLICATE,
                                chan_reg, mem_rdata.handle, 1'b0, '0);
                        end
                        wdb_pkg::ACT_REMOVE:
                        begin
                            pend_next = wdb_pkg::make_res(wdb_pkg::ST_OK,
                                chan_reg, mem_rdata.handle, 1'b0, '0);
                            if (scan_last)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            else
                            begin
                                state_next = S_SH_RD;
                            end
                        end
                        default:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = kick_ent;
                            pend_next = wdb_pkg::make_res(
                                urs.late ? wdb_pkg::ST_RECOVERED : wdb_pkg::ST_OK,
                                chan_reg, mem_rdata.handle, 1'b0, '0);
                        end
                    endcase
                end
                else if (scan_last)
                begin
                    state_next = S_END;
                end
                else
                begin
                    idx_next   = idx_p1[CW-1:0];
                    state_next = S_RD;
                end
            end

            // Close the gap left by a removed entry, moving later entries down.
            S_SH_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = idx_p1[AW-1:0];
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                mem_we   = 1'b1;
                idx_next = idx_p1[CW-1:0];
                if (idx_p2 < count_ext)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_FIN;
                end
            end

            // Scan finished without a matching id.
            S_END:
            begin
                state_next = S_FIN;
                case (act_reg)
                    wdb_pkg::ACT_REGISTER:
                    begin
                        pend_valid_next = 1'b1;
                        if (table_full)
                        begin
                            pend_next = wdb_pkg::make_res(wdb_pkg::ST_FULL,
                                chan_reg, '0, 1'b0, '0);
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = new_ent;
                            count_next = count_reg + CW'(1);
                            pend_next  = wdb_pkg::make_res(
                                raised ? wdb_pkg::ST_RAISED : wdb_pkg::ST_OK,
                                chan_reg, handle_reg, 1'b0, '0);
                        end
                    end
                    wdb_pkg::ACT_CHECK:
                    begin
                        pend_valid_next = pend_valid_reg;
                    end
                    default:
                    begin
                        pend_valid_next = 1'b1;
                        pend_next = wdb_pkg::make_res(wdb_pkg::ST_NOT_FOUND,
                            chan_reg, '0, 1'b0, '0);
                    end
                endcase
            end

            // Release the final result of the item.
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_res_next    = pend_valid_reg ? pend_reg
                                    : wdb_pkg::make_res(wdb_pkg::ST_NONE_DUE,
                                                        '0, '0, 1'b0, '0);
                    out_last_next   = 1'b1;
                    out_cnt_next    = wdb_pkg::ECNT_W'(count_reg);
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        out_cnt_reg  <= out_cnt_next;
        if (accept)
        begin
            act_reg    <= req.action;
            chan_reg   <= req.channel_id;
            handle_reg <= req.target_handle;
            thr_reg    <= req.threshold_ms;
            now_reg    <= req.now_ms;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = out_res_reg.status;
    assign rsp.result_channel    = out_res_reg.channel;
    assign rsp.result_handle     = out_res_reg.handle;
    assign rsp.backtrace_request = out_res_reg.backtrace;
    assign rsp.limit_ms          = out_res_reg.limit;
    assign rsp.entry_count       = out_cnt_reg;
    assign rsp.last_result       = out_last_reg;

    // No result is left behind when the block goes idle.
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left over in idle");

    // The table never holds more channels than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_ENTRIES))
        else $error("channel count beyond table size");

    // At most the allowed number of reports per check item.
    a_report_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= wdb_pkg::RES_CNT_W'(wdb_pkg::MAX_RESULTS))
        else $error("too many reports for one item");

    // The final result leaves as soon as the output has room, then idle.
    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (state_reg == S_IDLE) && out_valid_reg
        && out_last_reg)
        else $error("final result not released");

    // The channel count moves only when an entry is added or removed.
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != count_next) |-> (state_reg == S_END || state_reg == S_EV
        || state_reg == S_SH_WR))
        else $error("channel count changed outside add or remove");

endmodule

`default_nettype wire

>>> src/multi_channel_watchdog_backoff.sv
`default_nettype none

// Multi-channel watchdog with limit backoff.
// The req channel takes one item per action: register, remove, kick or check.
// The rsp channel returns the results of that item in order; last_result marks
// the final one. Register, remove and kick give one result, check gives one
// result per overdue channel (at most 16) or a single none-overdue result.
// Channels sit in a compact table memory that is read one entry at a time by
// a sequencer around a shared compare and add unit; each visited entry is
// first read and then evaluated. The block is ready for the next item in the
// same cycle that the final result reaches the output register. When
// rsp.ready is low the output register holds its result and the sequencer
// stops at the next result it has to hand over. Reset empties the table
// (count zero) at once, with no clearing pass, and loads the configuration
// registers with their defaults (minimum threshold 1000 ms, backtrace
// minimum 300000 ms). The APB port is to be written by the user only while
// the block is idle; the block itself does not enforce this.

module multi_channel_watchdog_backoff #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    wdb_req_if.sink                            req,
    wdb_rsp_if.source                          rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wdb_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [wdb_pkg::PDATA_W-1:0]   pwdata,
    output logic      [wdb_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    wdb_pkg::cfg_t       cfg;
    wdb_pkg::unit_res_t  urs;
    wdb_pkg::entry_t     mem_wdata;
    wdb_pkg::entry_t     mem_rdata;
    logic                use_thr;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [wdb_pkg::ID_W-1:0] item_chan;
    logic [wdb_pkg::MS_W-1:0] item_now;

    // Configuration registers.
    wdb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Channel table.
    wdb_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared compare and add unit.
    wdb_unit u_unit (
        .ent     (mem_rdata),
        .chan    (item_chan),
        .now     (item_now),
        .bt_min  (cfg.bt_min),
        .use_thr (use_thr),
        .res     (urs)
    );

    // Sequencer and output register.
    wdb_seq #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .urs       (urs),
        .use_thr   (use_thr),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .item_chan (item_chan),
        .item_now  (item_now)
    );

endmodule

`default_nettype wire
